[sv/lbp_pkg.sv]
// lbp_pkg: shared types and constants for the lsb-first bit packer
// no dependencies; imported by the front, queue, back and top-level modules

package lbp_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_SEND   = 2'd0;
    localparam logic [1:0] CMD_WINDUP = 2'd1;
    localparam logic [1:0] CMD_HEADER = 2'd2;
    localparam logic [1:0] CMD_RAW    = 2'd3;

    localparam int ACC_BITS  = 16;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;
    localparam int HELD_W    = 5;

    // one classified item: its bytes packed low byte first, and how many
    typedef struct packed {
        logic [MAX_BYTES*BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]            count;
    } t_job;

endpackage

[sv/lbp_front.sv]
// lbp_front: accepts input items, keeps the bit accumulator and turns each
// item into a job of up to six bytes; depends on lbp_pkg

module lbp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [1:0]            i_command,
    input  logic [15:0]           i_data_value,
    input  logic [4:0]            i_bit_length,
    output logic                  o_job_valid,
    output lbp_pkg::t_job         o_job
);
    import lbp_pkg::*;

    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [HELD_W-1:0]   r_held, n_held;

    logic [HELD_W-1:0]     len_sat;
    logic [ACC_BITS-1:0]   mask;
    logic [ACC_BITS-1:0]   value;
    logic [2*ACC_BITS-1:0] shifted;
    logic [HELD_W:0]       sum;
    logic [ACC_BITS-1:0]   merged;
    logic [CNT_W-1:0]      pre_cnt;
    logic [ACC_BITS-1:0]   pre_bytes;
    logic [2*ACC_BITS-1:0] hdr_tail;
    logic [MAX_BYTES*BYTE_W-1:0] hdr_bytes;

    // send path: saturate, mask and place the new bits above the held ones
    always_comb begin
        len_sat = (i_bit_length > HELD_W'(ACC_BITS)) ? HELD_W'(ACC_BITS) : i_bit_length;
        mask    = ACC_BITS'((17'd1 << len_sat) - 17'd1);
        value   = i_data_value & mask;
        shifted = {{ACC_BITS{1'b0}}, value} << r_held;
        sum     = {1'b0, r_held} + {1'b0, len_sat};
        merged  = r_acc | shifted[ACC_BITS-1:0];
    end

    // windup bytes and stored header bytes
    always_comb begin
        if (r_held > HELD_W'(BYTE_W)) begin
            pre_cnt   = CNT_W'(2);
            pre_bytes = r_acc;
        end else if (r_held != '0) begin
            pre_cnt   = CNT_W'(1);
            pre_bytes = {{BYTE_W{1'b0}}, r_acc[BYTE_W-1:0]};
        end else begin
            pre_cnt   = '0;
            pre_bytes = '0;
        end
        hdr_tail = {~i_data_value, i_data_value};
        case (pre_cnt)
            CNT_W'(2): hdr_bytes = {hdr_tail, pre_bytes};
            CNT_W'(1): hdr_bytes = {{BYTE_W{1'b0}}, hdr_tail, pre_bytes[BYTE_W-1:0]};
            default:   hdr_bytes = {{ACC_BITS{1'b0}}, hdr_tail};
        endcase
    end

    // classify the item and work out the next accumulator
    always_comb begin
        n_acc       = r_acc;
        n_held      = r_held;
        o_job.bytes = '0;
        o_job.count = '0;
        case (i_command)
            CMD_SEND: begin
                if (len_sat != '0) begin
                    if (sum > (HELD_W+1)'(ACC_BITS)) begin
                        o_job.bytes = {{ACC_BITS*2{1'b0}}, merged};
                        o_job.count = CNT_W'(2);
                        n_acc       = shifted[2*ACC_BITS-1:ACC_BITS];
                        n_held      = HELD_W'(sum - (HELD_W+1)'(ACC_BITS));
                    end else begin
                        n_acc  = merged;
                        n_held = sum[HELD_W-1:0];
                    end
                end
            end
            CMD_WINDUP: begin
                o_job.bytes = {{ACC_BITS*2{1'b0}}, pre_bytes};
                o_job.count = pre_cnt;
                n_acc       = '0;
                n_held      = '0;
            end
            CMD_HEADER: begin
                o_job.bytes = hdr_bytes;
                o_job.count = pre_cnt + CNT_W'(4);
                n_acc       = '0;
                n_held      = '0;
            end
            default: begin
                o_job.bytes = {{(MAX_BYTES-1)*BYTE_W{1'b0}}, i_data_value[BYTE_W-1:0]};
                o_job.count = CNT_W'(1);
            end
        endcase
        o_job_valid = i_fire && (o_job.count != '0);
    end

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_fire) begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

endmodule

[sv/lbp_queue.sv]
// lbp_queue: short job queue between the front and the back
// depends on lbp_pkg for the job type

module lbp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbp_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output lbp_pkg::t_job o_job,
    output logic          o_empty
);
    import lbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic             do_push, do_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_job   = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

[sv/lbp_back.sv]
// lbp_back: walks the head job byte by byte into the output register
// depends on lbp_pkg for the job type

module lbp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lbp_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run
);
    import lbp_pkg::*;

    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              load;
    logic              is_last;
    logic [BYTE_W-1:0] cur_byte;

    // pick the current byte of the head job
    always_comb begin
        cur_byte  = i_job.bytes[{r_idx, 3'b000} +: BYTE_W];
        is_last   = (r_idx == i_job.count - CNT_W'(1));
        load      = !i_job_empty && (!r_out_valid || i_pop);
        o_job_pop = load && is_last;
    end

    // byte index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_last ? '0 : r_idx + CNT_W'(1);
        end
    end

    // output register, refilled in the cycle its byte is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_last <= is_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

[sv/lsb_first_bit_packer.sv]
// lsb_first_bit_packer: top level; front classifier, job queue and byte back end
// depends on lbp_pkg, lbp_front, lbp_queue and lbp_back
// an item's first byte is registered in a queue slot and then in the output register
// throughput: one output byte per cycle while i_pop is high; a send item that emits
// a word gives two bytes and a stored header up to six; the queue absorbs bursts
// reset: synchronous, clears the accumulator, the queue and the output register

module lsb_first_bit_packer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_data_value,
    input  logic [4:0]  i_bit_length,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);
    import lbp_pkg::*;

    logic fire;
    logic job_valid;
    t_job job_in;
    t_job job_head;
    logic job_empty;
    logic job_pop;

    assign fire = i_push && !o_full;

    // front: accumulator and classification
    lbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_command    (i_command),
        .i_data_value (i_data_value),
        .i_bit_length (i_bit_length),
        .o_job_valid  (job_valid),
        .o_job        (job_in)
    );

    // job queue
    lbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job_in),
        .o_full  (o_full),
        .i_pop   (job_pop),
        .o_job   (job_head),
        .o_empty (job_empty)
    );

    // back: byte serialiser
    lbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_head),
        .i_job_empty   (job_empty),
        .o_job_pop     (job_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[sv/lbp_checker.sv]
// lbp_checker: port-level checks on the lsb-first bit packer
// bound to lsb_first_bit_packer; no package dependency

module lbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        o_full,
    input logic [1:0]  i_command,
    input logic [15:0] i_data_value,
    input logic [4:0]  i_bit_length,
    input logic        o_empty,
    input logic        i_pop,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result waiting after reset");

    // reset leaves room for input
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("full after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte)
            && $stable(o_last_of_run)))
        else $error("stalled result changed");

    // the output runs dry only after the final byte of an item
    a_dry_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_empty) && $past(i_rst_n)) |-> $past(o_last_of_run))
        else $error("output ran dry inside an item");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (.*);
